/* design/hse_pkg.sv */
// shared types, constants and command/status structs of the heap sort engine
package hse_pkg;

    localparam int DATA_W        = 32;
    localparam int SWAP_W        = 12;
    localparam int DEPTH_DEFAULT = 32;

    localparam logic [SWAP_W-1:0] SWAP_MAX = {SWAP_W{1'b1}};

    // controller states
    typedef enum logic [3:0] {
        ST_LOAD,
        ST_BUILD_INIT,
        ST_BUILD_NEXT,
        ST_BUILD_FETCH,
        ST_SIFT_START,
        ST_SIFT_LEFT,
        ST_SIFT_RIGHT,
        ST_SIFT_DECIDE,
        ST_SORT_INIT,
        ST_SORT_NEXT,
        ST_SORT_ROOT,
        ST_SORT_END,
        ST_EMIT_READ,
        ST_EMIT_LOAD
    } state_t;

    // datapath operations, one per cycle
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_BUILD_INIT,
        OP_BUILD_NEXT,
        OP_FETCH_V,
        OP_SIFT_START,
        OP_SIFT_LEFT,
        OP_SIFT_RIGHT,
        OP_SIFT_DECIDE,
        OP_SORT_INIT,
        OP_SORT_READ_ROOT,
        OP_SORT_ROOT,
        OP_SORT_END,
        OP_EMIT_READ,
        OP_EMIT_LOAD
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic iter_zero;
        logic iter_le1;
        logic left_ok;
        logic right_ok;
        logic top_is_node;
        logic out_free;
        logic emit_last;
    } sts_t;

endpackage

/* design/heap_sort_engine.sv */
// top level of the heap sort engine: controller plus datapath
//
// input channel (in_valid/in_ready, value, in_last): one signed value per
// transfer, written in turn into a DEPTH-entry ram; one per cycle while loading.
// values arriving once DEPTH are held are dropped and flag overflow. the
// transfer with in_last set closes the set and starts the sort.
// sort: in-place heapsort on the single-port-read ram. each sift level reads
// the left child, reads the right child, compares and writes back, skipping
// a child read that falls outside the heap; the ram's one read port makes the
// child reads run in turn. in_ready is low from the last transfer until the
// last result sits in the output register.
// output channel (out_valid/out_ready, sorted_value, out_last, swap_total,
// overflow): n results in ascending order, each read from the ram and then
// loaded into the output register; out_last marks the final one. every result
// carries the set's swap count (saturating at 4095) and overflow flag.
// a stalled receiver holds the output register; the engine waits for it.
// reset: counters and flags cleared, engine ready for a new set; ram content
// is not cleared, only entries written in the current set are read.
module heap_sort_engine #(
    parameter int DEPTH = hse_pkg::DEPTH_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [hse_pkg::DATA_W-1:0] value,
    input  logic                              in_last,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [hse_pkg::DATA_W-1:0] sorted_value,
    output logic                              out_last,
    output logic [hse_pkg::SWAP_W-1:0]        swap_total,
    output logic                              overflow
);

    // command and status between controller and datapath
    hse_pkg::cmd_t cmd;
    hse_pkg::sts_t sts;

    hse_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_last  (in_last),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    hse_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .value        (value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .sorted_value (sorted_value),
        .out_last     (out_last),
        .swap_total   (swap_total),
        .overflow     (overflow)
    );

endmodule

/* design/hse_ram.sv */
// generic single write port, single read port ram with registered read
module hse_ram #(
    parameter int WIDTH = hse_pkg::DATA_W,
    parameter int DEPTH = hse_pkg::DEPTH_DEFAULT
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/hse_ctrl.sv */
// controller state machine of the heap sort engine
module hse_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          in_last,
    output logic          in_ready,
    input  hse_pkg::sts_t sts,
    output hse_pkg::cmd_t cmd
);

    hse_pkg::state_t state_reg, state_next;
    logic            sort_phase_reg, sort_phase_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= hse_pkg::ST_LOAD;
            sort_phase_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            sort_phase_reg <= sort_phase_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        sort_phase_next = sort_phase_reg;
        cmd.op          = hse_pkg::OP_NONE;
        in_ready        = 1'b0;
        case (state_reg)
            hse_pkg::ST_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op = hse_pkg::OP_LOAD;
                    if (in_last)
                    begin
                        state_next = hse_pkg::ST_BUILD_INIT;
                    end
                end
            end
            hse_pkg::ST_BUILD_INIT:
            begin
                cmd.op          = hse_pkg::OP_BUILD_INIT;
                sort_phase_next = 1'b0;
                state_next      = hse_pkg::ST_BUILD_NEXT;
            end
            hse_pkg::ST_BUILD_NEXT:
            begin
                if (sts.iter_zero)
                begin
                    state_next = hse_pkg::ST_SORT_INIT;
                end
                else
                begin
                    cmd.op     = hse_pkg::OP_BUILD_NEXT;
                    state_next = hse_pkg::ST_BUILD_FETCH;
                end
            end
            hse_pkg::ST_BUILD_FETCH:
            begin
                cmd.op     = hse_pkg::OP_FETCH_V;
                state_next = hse_pkg::ST_SIFT_START;
            end
            hse_pkg::ST_SIFT_START:
            begin
                cmd.op     = hse_pkg::OP_SIFT_START;
                state_next = sts.left_ok ? hse_pkg::ST_SIFT_LEFT : hse_pkg::ST_SIFT_DECIDE;
            end
            hse_pkg::ST_SIFT_LEFT:
            begin
                cmd.op     = hse_pkg::OP_SIFT_LEFT;
                state_next = sts.right_ok ? hse_pkg::ST_SIFT_RIGHT : hse_pkg::ST_SIFT_DECIDE;
            end
            hse_pkg::ST_SIFT_RIGHT:
            begin
                cmd.op     = hse_pkg::OP_SIFT_RIGHT;
                state_next = hse_pkg::ST_SIFT_DECIDE;
            end
            hse_pkg::ST_SIFT_DECIDE:
            begin
                cmd.op = hse_pkg::OP_SIFT_DECIDE;
                if (!sts.top_is_node)
                begin
                    state_next = hse_pkg::ST_SIFT_START;
                end
                else if (sort_phase_reg)
                begin
                    state_next = hse_pkg::ST_SORT_NEXT;
                end
                else
                begin
                    state_next = hse_pkg::ST_BUILD_NEXT;
                end
            end
            hse_pkg::ST_SORT_INIT:
            begin
                cmd.op          = hse_pkg::OP_SORT_INIT;
                sort_phase_next = 1'b1;
                state_next      = hse_pkg::ST_SORT_NEXT;
            end
            hse_pkg::ST_SORT_NEXT:
            begin
                if (sts.iter_le1)
                begin
                    state_next = hse_pkg::ST_EMIT_READ;
                end
                else
                begin
                    cmd.op     = hse_pkg::OP_SORT_READ_ROOT;
                    state_next = hse_pkg::ST_SORT_ROOT;
                end
            end
            hse_pkg::ST_SORT_ROOT:
            begin
                cmd.op     = hse_pkg::OP_SORT_ROOT;
                state_next = hse_pkg::ST_SORT_END;
            end
            hse_pkg::ST_SORT_END:
            begin
                cmd.op     = hse_pkg::OP_SORT_END;
                state_next = hse_pkg::ST_SIFT_START;
            end
            hse_pkg::ST_EMIT_READ:
            begin
                cmd.op     = hse_pkg::OP_EMIT_READ;
                state_next = hse_pkg::ST_EMIT_LOAD;
            end
            hse_pkg::ST_EMIT_LOAD:
            begin
                if (sts.out_free)
                begin
                    cmd.op     = hse_pkg::OP_EMIT_LOAD;
                    state_next = sts.emit_last ? hse_pkg::ST_LOAD : hse_pkg::ST_EMIT_READ;
                end
            end
            default:
            begin
                state_next = hse_pkg::ST_LOAD;
            end
        endcase
    end

endmodule

/* design/hse_datapath.sv */
// datapath of the heap sort engine: element ram, sift registers, counters, output register
module hse_datapath #(
    parameter int DEPTH = hse_pkg::DEPTH_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  hse_pkg::cmd_t                     cmd,
    output hse_pkg::sts_t                     sts,
    input  logic signed [hse_pkg::DATA_W-1:0] value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [hse_pkg::DATA_W-1:0] sorted_value,
    output logic                              out_last,
    output logic [hse_pkg::SWAP_W-1:0]        swap_total,
    output logic                              overflow
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = AW + 2;

    // control counters
    logic [CW-1:0]             count_reg, count_next;
    logic [hse_pkg::SWAP_W-1:0] swap_reg, swap_next;
    logic                      ovf_reg, ovf_next;
    logic                      out_valid_reg, out_valid_next;

    // working registers
    logic [CW-1:0]                     iter_reg, iter_next;
    logic [CW-1:0]                     heap_n_reg, heap_n_next;
    logic [AW-1:0]                     node_reg, node_next;
    logic [AW-1:0]                     best_idx_reg, best_idx_next;
    logic [AW-1:0]                     k_reg, k_next;
    logic signed [hse_pkg::DATA_W-1:0] v_reg, v_next;
    logic signed [hse_pkg::DATA_W-1:0] best_val_reg, best_val_next;
    logic signed [hse_pkg::DATA_W-1:0] out_val_reg, out_val_next;
    logic                              out_last_reg, out_last_next;
    logic [hse_pkg::SWAP_W-1:0]        out_swap_reg, out_swap_next;
    logic                              out_ovf_reg, out_ovf_next;

    // ram port
    logic                       wr_en, rd_en;
    logic [AW-1:0]              wr_addr, rd_addr;
    logic [hse_pkg::DATA_W-1:0] wr_data, rd_raw;
    logic signed [hse_pkg::DATA_W-1:0] rd_data;

    logic [LW-1:0]              left_idx, right_idx, heap_ext;
    logic [CW-1:0]              iter_dec, k_inc;
    logic [AW-1:0]              end_addr;
    logic                       rd_gt_best;
    logic                       count_full;
    logic [hse_pkg::SWAP_W-1:0] swap_inc;

    hse_ram #(
        .WIDTH (hse_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_raw)
    );

    assign rd_data    = $signed(rd_raw);
    assign left_idx   = {1'b0, node_reg, 1'b1};
    assign right_idx  = {1'b0, node_reg, 1'b0} + LW'(2);
    assign heap_ext   = LW'(heap_n_reg);
    assign iter_dec   = iter_reg - CW'(1);
    assign end_addr   = iter_dec[AW-1:0];
    assign k_inc      = CW'(k_reg) + CW'(1);
    assign rd_gt_best = rd_data > best_val_reg;
    assign count_full = count_reg == CW'(DEPTH);
    assign swap_inc   = (swap_reg == hse_pkg::SWAP_MAX) ? swap_reg
                                                        : swap_reg + hse_pkg::SWAP_W'(1);

    assign sts.iter_zero   = iter_reg == '0;
    assign sts.iter_le1    = iter_reg <= CW'(1);
    assign sts.left_ok     = left_idx < heap_ext;
    assign sts.right_ok    = right_idx < heap_ext;
    assign sts.top_is_node = best_idx_reg == node_reg;
    assign sts.out_free    = !out_valid_reg || out_ready;
    assign sts.emit_last   = k_inc == count_reg;

    always_comb
    begin
        count_next     = count_reg;
        swap_next      = swap_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg && !out_ready;
        iter_next      = iter_reg;
        heap_n_next    = heap_n_reg;
        node_next      = node_reg;
        best_idx_next  = best_idx_reg;
        k_next         = k_reg;
        v_next         = v_reg;
        best_val_next  = best_val_reg;
        out_val_next   = out_val_reg;
        out_last_next  = out_last_reg;
        out_swap_next  = out_swap_reg;
        out_ovf_next   = out_ovf_reg;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = '0;
        rd_en          = 1'b0;
        rd_addr        = '0;
        case (cmd.op)
            hse_pkg::OP_LOAD:
            begin
                if (count_full)
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = count_reg[AW-1:0];
                    wr_data    = value;
                    count_next = count_reg + CW'(1);
                end
            end
            hse_pkg::OP_BUILD_INIT:
            begin
                iter_next   = count_reg >> 1;
                heap_n_next = count_reg;
                swap_next   = '0;
            end
            hse_pkg::OP_BUILD_NEXT:
            begin
                iter_next = iter_dec;
                node_next = end_addr;
                rd_en     = 1'b1;
                rd_addr   = end_addr;
            end
            hse_pkg::OP_FETCH_V:
            begin
                v_next = rd_data;
            end
            hse_pkg::OP_SIFT_START:
            begin
                best_idx_next = node_reg;
                best_val_next = v_reg;
                rd_en         = sts.left_ok;
                rd_addr       = left_idx[AW-1:0];
            end
            hse_pkg::OP_SIFT_LEFT:
            begin
                if (rd_gt_best)
                begin
                    best_idx_next = left_idx[AW-1:0];
                    best_val_next = rd_data;
                end
                rd_en   = sts.right_ok;
                rd_addr = right_idx[AW-1:0];
            end
            hse_pkg::OP_SIFT_RIGHT:
            begin
                if (rd_gt_best)
                begin
                    best_idx_next = right_idx[AW-1:0];
                    best_val_next = rd_data;
                end
            end
            hse_pkg::OP_SIFT_DECIDE:
            begin
                wr_en   = 1'b1;
                wr_addr = node_reg;
                if (sts.top_is_node)
                begin
                    // sifted value settles here
                    wr_data = v_reg;
                end
                else
                begin
                    // larger child moves up, sifted value goes one level down
                    wr_data   = best_val_reg;
                    node_next = best_idx_reg;
                    swap_next = swap_inc;
                end
            end
            hse_pkg::OP_SORT_INIT:
            begin
                iter_next = heap_n_reg;
                k_next    = '0;
            end
            hse_pkg::OP_SORT_READ_ROOT:
            begin
                rd_en   = 1'b1;
                rd_addr = '0;
            end
            hse_pkg::OP_SORT_ROOT:
            begin
                best_val_next = rd_data;
                rd_en         = 1'b1;
                rd_addr       = end_addr;
            end
            hse_pkg::OP_SORT_END:
            begin
                // root goes to the end of the heap, old end is sifted from the root
                wr_en       = 1'b1;
                wr_addr     = end_addr;
                wr_data     = best_val_reg;
                v_next      = rd_data;
                node_next   = '0;
                iter_next   = iter_dec;
                heap_n_next = iter_dec;
                swap_next   = swap_inc;
            end
            hse_pkg::OP_EMIT_READ:
            begin
                rd_en   = 1'b1;
                rd_addr = k_reg;
            end
            hse_pkg::OP_EMIT_LOAD:
            begin
                out_valid_next = 1'b1;
                out_val_next   = rd_data;
                out_last_next  = sts.emit_last;
                out_swap_next  = swap_reg;
                out_ovf_next   = ovf_reg;
                k_next         = k_reg + AW'(1);
                if (sts.emit_last)
                begin
                    count_next = '0;
                    swap_next  = '0;
                    ovf_next   = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            swap_reg      <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            swap_reg      <= swap_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        iter_reg     <= iter_next;
        heap_n_reg   <= heap_n_next;
        node_reg     <= node_next;
        best_idx_reg <= best_idx_next;
        k_reg        <= k_next;
        v_reg        <= v_next;
        best_val_reg <= best_val_next;
        out_val_reg  <= out_val_next;
        out_last_reg <= out_last_next;
        out_swap_reg <= out_swap_next;
        out_ovf_reg  <= out_ovf_next;
    end

    assign out_valid    = out_valid_reg;
    assign sorted_value = out_val_reg;
    assign out_last     = out_last_reg;
    assign swap_total   = out_swap_reg;
    assign overflow     = out_ovf_reg;

endmodule

/* bench/tb_heap_sort_engine.sv */
// self-checking testbench of the heap sort engine with a heapsort predictor
module tb_heap_sort_engine;

    import hse_pkg::*;

    localparam int DEPTH      = DEPTH_DEFAULT;
    localparam int MAX_REPORT = 10;
    localparam int TAIL_ITEMS = 50;    // last transfers of the run go without idling
    localparam int LONG_HOLD  = 400;   // receiver hold-off that backs up the engine
    localparam int HOLD_AT    = 40;    // results seen before the hold-off starts
    localparam int DRAIN_WAIT = 200;   // quiet cycles after the last result

    // how the values of one data set are drawn
    typedef enum int {
        VAL_WIDE,      // any 32-bit value
        VAL_NARROW,    // a few values, so duplicates are common
        VAL_EDGE       // extremes, values next to them, zero and minus one
    } val_mode_t;

    typedef struct {
        logic signed [DATA_W-1:0] val;
        logic                     last;
    } send_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] val;
        logic                     last;
        logic [SWAP_W-1:0]        swaps;
        logic                     ovf;
    } sorted_item_t;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     in_valid  = 1'b0;
    logic                     in_ready;
    logic signed [DATA_W-1:0] value     = '0;
    logic                     in_last   = 1'b0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic signed [DATA_W-1:0] sorted_value;
    logic                     out_last;
    logic [SWAP_W-1:0]        swap_total;
    logic                     overflow;

    // items waiting to be offered, and results the engine still owes
    send_item_t   pending_items[$];
    sorted_item_t sorted_expect[$];

    // predictor copy of the engine state
    logic signed [DATA_W-1:0] held [DEPTH];
    int                       held_count    = 0;
    logic                     dropped_flag  = 1'b0;

    int total_items     = 0;
    int accepted_count  = 0;
    int results_seen    = 0;
    int mismatch_count  = 0;
    int send_gap        = 0;
    int recv_gap        = 0;
    int send_idle_pct   = 20;
    int recv_idle_pct   = 20;
    int long_hold_left  = 0;
    bit long_hold_done  = 1'b0;
    bit quiet_tail      = 1'b0;

    heap_sort_engine #(
        .DEPTH(DEPTH)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .value       (value),
        .in_last     (in_last),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .sorted_value(sorted_value),
        .out_last    (out_last),
        .swap_total  (swap_total),
        .overflow    (overflow)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // predictor: max-heap build, then sort-down, counting every swap
    // ---------------------------------------------------------------

    task automatic swap_held(input int p, input int q, inout logic [SWAP_W-1:0] swaps);
        logic signed [DATA_W-1:0] t;
        t       = held[p];
        held[p] = held[q];
        held[q] = t;
        // the count sticks at its maximum
        if (swaps != SWAP_MAX)
            swaps = swaps + 1'b1;
    endtask

    // iterative sift-down of one node within a heap of n entries
    task automatic sift_heap(input int n, input int start, inout logic [SWAP_W-1:0] swaps);
        int node;
        int top;
        int lc;
        int rc;
        bit settled;
        node    = start;
        settled = 1'b0;
        while (!settled)
        begin
            lc  = 2 * node + 1;
            rc  = 2 * node + 2;
            top = node;
            // a child wins only when strictly greater, left child tested first
            if (lc < n && held[lc] > held[top])
                top = lc;
            if (rc < n && held[rc] > held[top])
                top = rc;
            if (top == node)
                settled = 1'b1;
            else
            begin
                swap_held(top, node, swaps);
                node = top;
            end
        end
    endtask

    // one accepted input transfer: store or drop it, and on the closing
    // transfer sort the set and queue one result per held value
    task automatic take_value(input logic signed [DATA_W-1:0] v, input logic closes_set);
        logic [SWAP_W-1:0] swaps;
        sorted_item_t      r;
        int                n;
        if (held_count < DEPTH)
        begin
            held[held_count] = v;
            held_count++;
        end
        else
            dropped_flag = 1'b1;
        if (closes_set)
        begin
            n     = held_count;
            swaps = '0;
            for (int i = n / 2; i > 0; i--)
                sift_heap(n, i - 1, swaps);
            for (int i = n; i > 1; i--)
            begin
                swap_held(0, i - 1, swaps);
                sift_heap(i - 1, 0, swaps);
            end
            for (int k = 0; k < n; k++)
            begin
                r.val   = held[k];
                r.last  = (k == n - 1);
                r.swaps = swaps;
                r.ovf   = dropped_flag;
                sorted_expect.push_back(r);
            end
            held_count   = 0;
            dropped_flag = 1'b0;
        end
    endtask

    // ---------------------------------------------------------------
    // stimulus generation
    // ---------------------------------------------------------------

    function automatic logic signed [DATA_W-1:0] pick_value(input val_mode_t mode);
        logic [DATA_W-1:0] v;
        case (mode)
            VAL_NARROW:
                v = $urandom_range(0, 6) - 3;
            VAL_EDGE:
                case ($urandom_range(0, 5))
                    0: v = 32'h8000_0000;
                    1: v = 32'h8000_0001;
                    2: v = 32'h7fff_ffff;
                    3: v = 32'h7fff_fffe;
                    4: v = 32'h0000_0000;
                    default: v = 32'hffff_ffff;
                endcase
            default:
                v = $urandom;
        endcase
        return v;
    endfunction

    task automatic add_item(input logic signed [DATA_W-1:0] v, input logic closes_set);
        send_item_t it;
        it.val  = v;
        it.last = closes_set;
        pending_items.push_back(it);
    endtask

    // a random data set; sizes above DEPTH exercise the dropped-item path,
    // including a closing transfer that is itself dropped
    task automatic add_set(input int sz, input val_mode_t mode);
        for (int i = 0; i < sz; i++)
            add_item(pick_value(mode), i == sz - 1);
    endtask

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------

    initial
    begin
        int        sz;
        int        pick;
        val_mode_t mode;

        // single value: no swaps at all
        add_item(32'sh8000_0000, 1'b1);
        // two values at the extremes of the signed range
        add_item(32'sh7fff_ffff, 1'b0);
        add_item(32'sh8000_0000, 1'b1);
        // equal values: no child is strictly greater, so sifts swap nothing; only the root-to-end moves count
        for (int i = 0; i < 4; i++)
            add_item(32'sd5, i == 3);
        // mixed signs and alternating bit patterns, every bit both ways
        add_item(32'sh0000_0000, 1'b0);
        add_item(-32'sd1,        1'b0);
        add_item(32'sd1,         1'b0);
        add_item(32'sh7fff_ffff, 1'b0);
        add_item(32'sh8000_0000, 1'b0);
        add_item(32'sh5555_5555, 1'b0);
        add_item(32'shaaaa_aaaa, 1'b0);
        add_item(-32'sd2,        1'b1);
        // already sorted high to low
        for (int i = 5; i > 0; i--)
            add_item(i, i == 1);

        // overflow, dropped closing transfer, then a full store
        add_set(DEPTH + 1, VAL_WIDE);
        add_set(DEPTH + 5, VAL_NARROW);
        add_set(DEPTH, VAL_WIDE);

        while (pending_items.size() < 330)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                sz = $urandom_range(DEPTH + 1, DEPTH + 6);
            else if (pick == 1)
                sz = ($urandom_range(0, 1) != 0) ? DEPTH : 1;
            else if (pick < 6)
                sz = $urandom_range(13, DEPTH);
            else
                sz = $urandom_range(1, 12);
            pick = $urandom_range(0, 9);
            mode = (pick < 6) ? VAL_WIDE : (pick < 9) ? VAL_NARROW : VAL_EDGE;
            add_set(sz, mode);
        end
        total_items = pending_items.size();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // every transfer taken, then every result handed over
        while (accepted_count != total_items)
            @(posedge clk);
        while (sorted_expect.size() != 0)
            @(posedge clk);
        // watch for stray results
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatch_count == 0 && sorted_expect.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    // ---------------------------------------------------------------
    // input driver: offers items from the pending queue with idle bursts
    // ---------------------------------------------------------------

    always @(posedge clk)
    begin
        send_item_t it;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap  = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                take_value(value, in_last);
                accepted_count <= accepted_count + 1;
                // new idle mix for each data set
                if (in_last)
                begin
                    case ($urandom_range(0, 3))
                        0, 1: send_idle_pct = 0;
                        2:    send_idle_pct = 15;
                        default: send_idle_pct = 40;
                    endcase
                end
            end
            quiet_tail <= (pending_items.size() < TAIL_ITEMS);
            // the bus is free once the offered item went through or none was offered
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_items.size() != 0)
                begin
                    it = pending_items.pop_front();
                    in_valid <= 1'b1;
                    value    <= it.val;
                    in_last  <= it.last;
                    if (!quiet_tail && $urandom_range(0, 99) < send_idle_pct)
                        send_gap = $urandom_range(1, 10);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // long receiver hold-off, counted here; the sender keeps offering,
    // so the engine backs up and holds in_ready low
    // ---------------------------------------------------------------

    always @(posedge clk)
    begin
        if (!rst_n)
            long_hold_left <= 0;
        else if (long_hold_left != 0)
            long_hold_left <= long_hold_left - 1;
        else if (!long_hold_done && results_seen >= HOLD_AT)
        begin
            long_hold_left <= LONG_HOLD;
            long_hold_done <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // output monitor: checks each result transfer against the oldest
    // expectation and stalls the engine in random bursts
    // ---------------------------------------------------------------

    always @(posedge clk)
    begin
        sorted_item_t e;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_gap   = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen <= results_seen + 1;
                if (sorted_expect.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORT)
                        $display("unexpected result: value %0d last %0d swaps %0d ovf %0d",
                                 sorted_value, out_last, swap_total, overflow);
                end
                else
                begin
                    e = sorted_expect.pop_front();
                    if (sorted_value !== e.val || out_last !== e.last ||
                        swap_total !== e.swaps || overflow !== e.ovf)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORT)
                            $display("mismatch: exp value %0d last %0d swaps %0d ovf %0d, %s",
                                     e.val, e.last, e.swaps, e.ovf,
                                     $sformatf("got value %0d last %0d swaps %0d ovf %0d",
                                               sorted_value, out_last, swap_total,
                                               overflow));
                    end
                end
                if (out_last)
                    recv_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 50);
            end
            if (recv_gap > 0)
            begin
                recv_gap--;
                out_ready <= 1'b0;
            end
            else if (long_hold_left != 0)
                out_ready <= 1'b0;
            else
            begin
                out_ready <= 1'b1;
                if (!quiet_tail && $urandom_range(0, 99) < recv_idle_pct)
                    recv_gap = $urandom_range(1, 10);
            end
        end
    end

endmodule

/* files.f */
design/hse_pkg.sv
design/hse_ram.sv
design/hse_ctrl.sv
design/hse_datapath.sv
design/heap_sort_engine.sv
bench/tb_heap_sort_engine.sv
